// ----- hdl/vdl_pkg.sv -----
// Shared types, codes and helpers for the vector display list decoder.
`default_nettype none

package vdl_pkg;

   // Command opcodes as they appear in the byte stream.
   localparam logic [7:0] OP_BRIGHT = 8'd1;
   localparam logic [7:0] OP_DOT    = 8'd2;
   localparam logic [7:0] OP_LINE   = 8'd3;
   localparam logic [7:0] OP_PATH   = 8'd4;
   localparam logic [7:0] OP_END    = 8'd5;

   // Brightness after reset.
   localparam logic [7:0] BRIGHT_RESET = 8'h7f;

   // Result kinds.
   localparam logic KIND_SEGMENT = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // Width of a scaled coordinate.
   localparam int COORD_W = 15;

   // Segment queue between the parser and the output stage.
   localparam int Q_DEPTH  = 4;
   localparam int Q_ADDR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

   // Parser phases.
   typedef enum logic [2:0] {
      PH_OPCODE,
      PH_BRIGHT,
      PH_DOT,
      PH_LINE,
      PH_PCOUNT,
      PH_PFIRST,
      PH_PPOINT
   } phase_type;

   // One decoded segment with raw signed-byte coordinates.
   typedef struct packed {
      logic       kind;
      logic [7:0] x0;
      logic [7:0] y0;
      logic [7:0] x1;
      logic [7:0] y1;
      logic [7:0] intensity;
   } seg_type;

   // Write request from the parser into the queue.
   typedef struct packed {
      logic    push;
      seg_type seg;
   } qwrite_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } qstatus_type;

   // Signed byte times 128, as a 15-bit two's complement value.
   function automatic logic [COORD_W-1:0] scale_coord(input logic [7:0] b);
      scale_coord = {b, 7'b0};
   endfunction

endpackage

`default_nettype wire

// ----- hdl/vdl_parser.sv -----
// Front end: parses the command byte stream and produces segment beats.
`default_nettype none

module vdl_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               byte_accept,
   input  wire logic [7:0]         stream_byte,
   output vdl_pkg::qwrite_type     qwrite
);
   import vdl_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [1:0] arg_idx_ff, arg_idx_in;
   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];
   logic [7:0] prev_x_ff, prev_x_in;
   logic [7:0] prev_y_ff, prev_y_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] bright_ff, bright_in;
   logic [7:0] remaining_dec;

   assign remaining_dec = remaining_ff - 8'd1;

   // Next state and segment generation for one accepted byte.
   always_comb begin
      phase_in     = phase_ff;
      arg_idx_in   = arg_idx_ff;
      held_in      = held_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      remaining_in = remaining_ff;
      bright_in    = bright_ff;
      qwrite.push  = 1'b0;
      qwrite.seg   = '{kind: KIND_SEGMENT, x0: held_ff[0], y0: held_ff[1],
                       x1: held_ff[2], y1: stream_byte, intensity: bright_ff};
      if (byte_accept) begin
         unique case (phase_ff)
            PH_OPCODE: begin
               arg_idx_in = 2'd0;
               case (stream_byte)
                  OP_BRIGHT: phase_in = PH_BRIGHT;
                  OP_DOT:    phase_in = PH_DOT;
                  OP_LINE:   phase_in = PH_LINE;
                  OP_PATH:   phase_in = PH_PCOUNT;
                  OP_END: begin
                     qwrite.push = 1'b1;
                     qwrite.seg  = '{kind: KIND_END, x0: 8'd0, y0: 8'd0,
                                     x1: 8'd0, y1: 8'd0, intensity: 8'd0};
                  end
                  default: ;
               endcase
            end
            PH_BRIGHT: begin
               bright_in  = stream_byte;
               phase_in   = PH_OPCODE;
               arg_idx_in = 2'd0;
            end
            PH_DOT: begin
               if (arg_idx_ff == 2'd0) begin
                  held_in[0] = stream_byte;
                  arg_idx_in = 2'd1;
               end else begin
                  qwrite.push   = 1'b1;
                  qwrite.seg.y0 = stream_byte;
                  qwrite.seg.x1 = held_ff[0];
                  phase_in      = PH_OPCODE;
                  arg_idx_in    = 2'd0;
               end
            end
            PH_LINE, PH_PFIRST: begin
               if (arg_idx_ff != 2'd3) begin
                  held_in[arg_idx_ff] = stream_byte;
                  arg_idx_in          = arg_idx_ff + 2'd1;
               end else begin
                  qwrite.push = 1'b1;
                  arg_idx_in  = 2'd0;
                  if (phase_ff == PH_PFIRST && remaining_ff != 8'd0) begin
                     prev_x_in = held_ff[2];
                     prev_y_in = stream_byte;
                     phase_in  = PH_PPOINT;
                  end else begin
                     phase_in = PH_OPCODE;
                  end
               end
            end
            PH_PCOUNT: begin
               remaining_in = (stream_byte == 8'd0) ? 8'd0 : stream_byte - 8'd1;
               phase_in     = PH_PFIRST;
               arg_idx_in   = 2'd0;
            end
            PH_PPOINT: begin
               if (arg_idx_ff == 2'd0) begin
                  held_in[0] = stream_byte;
                  arg_idx_in = 2'd1;
               end else begin
                  qwrite.push   = 1'b1;
                  qwrite.seg.x0 = prev_x_ff;
                  qwrite.seg.y0 = prev_y_ff;
                  qwrite.seg.x1 = held_ff[0];
                  prev_x_in     = held_ff[0];
                  prev_y_in     = stream_byte;
                  remaining_in  = remaining_dec;
                  arg_idx_in    = 2'd0;
                  if (remaining_dec == 8'd0) begin
                     phase_in = PH_OPCODE;
                  end
               end
            end
            default: begin
               phase_in   = PH_OPCODE;
               arg_idx_in = 2'd0;
            end
         endcase
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPCODE;
         arg_idx_ff   <= 2'd0;
         held_ff[0]   <= 8'd0;
         held_ff[1]   <= 8'd0;
         held_ff[2]   <= 8'd0;
         prev_x_ff    <= 8'd0;
         prev_y_ff    <= 8'd0;
         remaining_ff <= 8'd0;
         bright_ff    <= BRIGHT_RESET;
      end else begin
         phase_ff     <= phase_in;
         arg_idx_ff   <= arg_idx_in;
         held_ff      <= held_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         remaining_ff <= remaining_in;
         bright_ff    <= bright_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/vdl_queue.sv -----
// Short segment queue that decouples the parser from the output stage.
`default_nettype none

module vdl_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire vdl_pkg::qwrite_type qwrite,
   input  wire logic                pop,
   output vdl_pkg::seg_type         head,
   output vdl_pkg::qstatus_type     status
);
   import vdl_pkg::*;

   seg_type              mem_ff [Q_DEPTH];
   logic [Q_ADDR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = qwrite.push;
   assign do_pop       = pop;
   assign head         = mem_ff[rd_ptr_ff];

   // Pointer and fill-level update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; only written entries are ever read.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= qwrite.seg;
      end
   end

   // The fill level never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue fill level beyond depth");

   // The parser never writes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !(do_push && !do_pop))
      else $error("queue overflow");

   // The output stage never reads an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !do_pop)
      else $error("queue underflow");

   // A pop with no push lowers the level by one.
   a_pop_level: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue level not lowered on pop");

endmodule

`default_nettype wire

// ----- hdl/vdl_emitter.sv -----
// Back end: scales queued segments and holds them in the output register.
`default_nettype none

module vdl_emitter (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire vdl_pkg::seg_type     head,
   input  wire vdl_pkg::qstatus_type status,
   output logic                      pop,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic                      out_kind,
   output logic [71:0]               out_data
);
   import vdl_pkg::*;

   logic        valid_ff, valid_in;
   logic        kind_ff;
   logic [71:0] data_ff;

   // Load a new beat when the register is empty or being taken.
   assign pop       = !status.empty && (!valid_ff || out_ready);
   assign valid_in  = pop || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register: scaled coordinates and intensity.
   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= head.kind;
         data_ff <= {4'd0, head.intensity, scale_coord(head.y1), scale_coord(head.x1),
                     scale_coord(head.y0), scale_coord(head.x0)};
      end
   end

endmodule

`default_nettype wire

// ----- hdl/vector_display_list_decoder.sv -----
// Top level of the vector display list decoder.
//
//  channel  direction  contents
//  req_     in         one stream byte per beat
//  rsp_     out        one segment or end-of-list marker per beat
//
// One byte is taken each cycle while req_tready is high; the parser updates its
// state in the cycle the byte is accepted, and a resulting segment passes through
// the queue into the output register. req_tready falls only while the four-entry
// segment queue is full, so bytes keep flowing while a result waits on rsp_.
// Reset is synchronous and returns the parser to waiting for an opcode with
// brightness 127 and empties the queue and the output register.
`default_nettype none

module vector_display_list_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] stream_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [14:0] start_x, [29:15] start_y,
                                         // [44:30] end_x, [59:45] end_y,
                                         // [67:60] intensity, [71:68] zero
   output logic             rsp_tuser    // [0] kind
);
   import vdl_pkg::*;

   qwrite_type  qwrite;
   qstatus_type qstatus;
   seg_type     head;
   logic        pop;
   logic        byte_accept;

   // A byte is accepted whenever the queue can take the segment it may cause.
   assign req_tready  = !qstatus.full;
   assign byte_accept = req_tvalid && req_tready;

   vdl_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .stream_byte (req_tdata),
      .qwrite      (qwrite)
   );

   vdl_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .qwrite (qwrite),
      .pop    (pop),
      .head   (head),
      .status (qstatus)
   );

   vdl_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (qstatus),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_data  (rsp_tdata)
   );

endmodule

`default_nettype wire
